>>> hdl/thrd_pkg.sv
// Shared types and constants for the touch hold and auto-repeat detector.
`default_nettype none

package thrd_pkg;

  // Input request commands
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_MOVE    = 2'd2,
    CMD_RELEASE = 2'd3
  } thrd_cmd_t;

  // Register index, taken from the word address of the configuration port
  typedef enum logic [2:0] {
    REG_CENTRE_X     = 3'd0,
    REG_CENTRE_Y     = 3'd1,
    REG_ZONE_RADIUS  = 3'd2,
    REG_DELAY_TICKS  = 3'd3,
    REG_REPEAT_TICKS = 3'd4
  } thrd_reg_t;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned RAD_W   = 15;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned COUNT_W = 16;

  // Repeat interval that disables auto-repeat
  localparam logic [TICK_W-1:0]  INFINITE  = '0;
  localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

>>> hdl/touch_hold_repeat_detector.sv
// Top level of the touch hold detector with auto-repeat over a circular zone.
`default_nettype none

// Each request is a tick, press, move or release with a position. A press
// strictly inside the circle around the configured centre arms a tick timer;
// after delay_ticks ticks a count of 1 is reported, then one further count
// every repeat_ticks ticks (zero disables repeats). A move outside the circle
// or any release disarms the timer and, if a hold had been reported, emits a
// final count of 0. The block takes one request per clock cycle unless a
// stalled result holds the pipeline. A request passes through the input
// register, then the squaring stage (two 17x17 multipliers), then the output
// register, which is loaded from the distance compare and the timer update.
// While the output register holds a result that is stalled, the whole
// pipeline holds. Configuration is to be written through the APB-style port
// only while idle; the block itself does not enforce this.

module touch_hold_repeat_detector (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Request channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_command,
  input  wire logic signed [thrd_pkg::COORD_W-1:0] in_pos_x,
  input  wire logic signed [thrd_pkg::COORD_W-1:0] in_pos_y,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [thrd_pkg::COUNT_W-1:0]          out_hold_count,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [thrd_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int unsigned DIFF_W = thrd_pkg::COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * thrd_pkg::COORD_W;
  localparam int unsigned R2_W   = 2 * thrd_pkg::RAD_W;

  // Configuration registers
  logic signed [thrd_pkg::COORD_W-1:0] centre_x_r;
  logic signed [thrd_pkg::COORD_W-1:0] centre_y_r;
  logic [thrd_pkg::RAD_W-1:0]          zone_radius_r;
  logic [R2_W-1:0]                     radius_sq_r;
  logic [thrd_pkg::TICK_W-1:0]         delay_ticks_r;
  logic [thrd_pkg::TICK_W-1:0]         repeat_ticks_r;

  logic            cfg_write;
  thrd_pkg::thrd_reg_t cfg_reg;

  // Pipeline registers
  logic                                s1_valid_r;
  thrd_pkg::thrd_cmd_t                 s1_cmd_r;
  logic signed [thrd_pkg::COORD_W-1:0] s1_x_r;
  logic signed [thrd_pkg::COORD_W-1:0] s1_y_r;

  logic                                s2_valid_r;
  thrd_pkg::thrd_cmd_t                 s2_cmd_r;
  logic [SQ_W-1:0]                     s2_dx_sq_r;
  logic [SQ_W-1:0]                     s2_dy_sq_r;

  // Detector state
  logic                                armed_r, armed_nxt;
  logic                                held_r, held_nxt;
  logic [thrd_pkg::TICK_W-1:0]         elapsed_r, elapsed_nxt;
  logic [thrd_pkg::COUNT_W-1:0]        detections_r, detections_nxt;

  // Output register
  logic                                out_valid_r;
  logic [thrd_pkg::COUNT_W-1:0]        out_hold_count_r;

  logic                                advance;
  logic signed [DIFF_W-1:0]            dx, dy;
  logic signed [2*DIFF_W-1:0]          dx_sq, dy_sq;
  logic [SQ_W:0]                       dist_sq;
  logic                                zone_hit;
  logic [thrd_pkg::TICK_W-1:0]         elapsed_inc;
  logic                                emit;
  logic [thrd_pkg::COUNT_W-1:0]        emit_count;

  // Configuration access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_reg   = thrd_pkg::thrd_reg_t'(paddr[thrd_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r     <= '0;
      centre_y_r     <= '0;
      zone_radius_r  <= '0;
      radius_sq_r    <= '0;
      delay_ticks_r  <= '0;
      repeat_ticks_r <= '0;
    end else if (cfg_write) begin
      case (cfg_reg)
        thrd_pkg::REG_CENTRE_X: centre_x_r <= pwdata[thrd_pkg::COORD_W-1:0];
        thrd_pkg::REG_CENTRE_Y: centre_y_r <= pwdata[thrd_pkg::COORD_W-1:0];
        thrd_pkg::REG_ZONE_RADIUS: begin
          zone_radius_r <= pwdata[thrd_pkg::RAD_W-1:0];
          radius_sq_r   <= pwdata[thrd_pkg::RAD_W-1:0] * pwdata[thrd_pkg::RAD_W-1:0];
        end
        thrd_pkg::REG_DELAY_TICKS:  delay_ticks_r  <= pwdata[thrd_pkg::TICK_W-1:0];
        thrd_pkg::REG_REPEAT_TICKS: repeat_ticks_r <= pwdata[thrd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    case (cfg_reg)
      thrd_pkg::REG_CENTRE_X:     prdata = {{(32-thrd_pkg::COORD_W){centre_x_r[15]}}, centre_x_r};
      thrd_pkg::REG_CENTRE_Y:     prdata = {{(32-thrd_pkg::COORD_W){centre_y_r[15]}}, centre_y_r};
      thrd_pkg::REG_ZONE_RADIUS:  prdata = {{(32-thrd_pkg::RAD_W){1'b0}}, zone_radius_r};
      thrd_pkg::REG_DELAY_TICKS:  prdata = {{(32-thrd_pkg::TICK_W){1'b0}}, delay_ticks_r};
      thrd_pkg::REG_REPEAT_TICKS: prdata = {{(32-thrd_pkg::TICK_W){1'b0}}, repeat_ticks_r};
      default:                    prdata = '0;
    endcase
  end

  // The whole pipeline moves unless a result waits on a stalled output
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_cmd_r <= thrd_pkg::thrd_cmd_t'(in_command);
      s1_x_r   <= in_pos_x;
      s1_y_r   <= in_pos_y;
    end
  end

  // Offsets from the centre and their squares
  assign dx    = DIFF_W'(s1_x_r) - DIFF_W'(centre_x_r);
  assign dy    = DIFF_W'(s1_y_r) - DIFF_W'(centre_y_r);
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_dx_sq_r <= dx_sq[SQ_W-1:0];
      s2_dy_sq_r <= dy_sq[SQ_W-1:0];
    end
  end

  // Strict inside test against the squared radius
  assign dist_sq  = {1'b0, s2_dx_sq_r} + {1'b0, s2_dy_sq_r};
  assign zone_hit = dist_sq < {{(SQ_W+1-R2_W){1'b0}}, radius_sq_r};

  assign elapsed_inc = (elapsed_r == thrd_pkg::TICK_MAX) ? elapsed_r : elapsed_r + 1'b1;

  function automatic logic [thrd_pkg::COUNT_W-1:0] COUNT_W1();
    return {{(thrd_pkg::COUNT_W-1){1'b0}}, 1'b1};
  endfunction

  // Timer and hold state update
  always_comb begin
    armed_nxt      = armed_r;
    held_nxt       = held_r;
    elapsed_nxt    = elapsed_r;
    detections_nxt = detections_r;
    emit           = 1'b0;
    emit_count     = '0;
    case (s2_cmd_r)
      thrd_pkg::CMD_TICK: begin
        if (armed_r) begin
          elapsed_nxt = elapsed_inc;
          if (detections_r == '0) begin
            if (elapsed_inc >= delay_ticks_r) begin
              held_nxt       = 1'b1;
              detections_nxt = COUNT_W1();
              elapsed_nxt    = '0;
              emit           = 1'b1;
              emit_count     = COUNT_W1();
            end
          end else if (repeat_ticks_r != thrd_pkg::INFINITE &&
                       elapsed_inc >= repeat_ticks_r) begin
            if (detections_r != thrd_pkg::COUNT_MAX) begin
              detections_nxt = detections_r + 1'b1;
            end
            elapsed_nxt = '0;
            emit        = 1'b1;
            emit_count  = (detections_r != thrd_pkg::COUNT_MAX) ?
                          detections_r + 1'b1 : detections_r;
          end
        end
      end
      thrd_pkg::CMD_PRESS: begin
        if (zone_hit) begin
          armed_nxt      = 1'b1;
          elapsed_nxt    = '0;
          detections_nxt = '0;
        end
      end
      thrd_pkg::CMD_MOVE, thrd_pkg::CMD_RELEASE: begin
        // A move that stays inside leaves the hold alone
        if (s2_cmd_r == thrd_pkg::CMD_RELEASE || !zone_hit) begin
          armed_nxt   = 1'b0;
          elapsed_nxt = '0;
          if (held_r) begin
            held_nxt       = 1'b0;
            detections_nxt = '0;
            emit           = 1'b1;
            emit_count     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      held_r       <= 1'b0;
      elapsed_r    <= '0;
      detections_r <= '0;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r && emit;
      if (s2_valid_r) begin
        armed_r      <= armed_nxt;
        held_r       <= held_nxt;
        elapsed_r    <= elapsed_nxt;
        detections_r <= detections_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance && s2_valid_r && emit) begin
      out_hold_count_r <= emit_count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hold_count = out_hold_count_r;

  // The timer is cleared whenever the detector is disarmed
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> elapsed_r == '0)
    else $error("elapsed ticks nonzero while disarmed");

  // A nonzero count always belongs to a reported hold
  a_count_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    detections_r != '0 |-> held_r)
    else $error("detection count without a hold");

  // The input side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with an empty output register");

  // A result produced by the update stage reaches the output register
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s2_valid_r && emit |=> out_valid_r && out_hold_count_r == $past(emit_count))
    else $error("result lost between update and output register");

  // The end-of-hold marker leaves the hold cleared
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hold_count_r == '0 |-> !held_r)
    else $error("end-of-hold result while hold still set");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the touch hold detector with auto-repeat.
`timescale 1ns / 100ps

module tb;

  localparam logic [thrd_pkg::COUNT_W-1:0] COUNT_ONE = {{(thrd_pkg::COUNT_W-1){1'b0}}, 1'b1};

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [1:0]                          in_command = thrd_pkg::CMD_TICK;
  logic signed [thrd_pkg::COORD_W-1:0] in_pos_x = '0;
  logic signed [thrd_pkg::COORD_W-1:0] in_pos_y = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [thrd_pkg::COUNT_W-1:0]        out_hold_count;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [thrd_pkg::ADDR_W-1:0]         paddr = '0;
  logic [31:0]                         pwdata = '0;
  logic [31:0]                         prdata;
  logic                                pready;

  touch_hold_repeat_detector uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hold_count (out_hold_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // Zone and timing settings as last written to the block.
  logic signed [thrd_pkg::COORD_W-1:0] zone_cx = '0;
  logic signed [thrd_pkg::COORD_W-1:0] zone_cy = '0;
  logic [thrd_pkg::RAD_W-1:0]          zone_r = '0;
  logic [thrd_pkg::TICK_W-1:0]         delay_len = '0;
  logic [thrd_pkg::TICK_W-1:0]         repeat_len = '0;

  // Predicted hold state.
  logic                                zone_armed = 1'b0;
  logic                                hold_seen = 1'b0;
  logic [thrd_pkg::TICK_W-1:0]         tick_count = '0;
  logic [thrd_pkg::COUNT_W-1:0]        repeat_num = '0;

  logic [thrd_pkg::COUNT_W-1:0]        hold_counts_due[$];
  int unsigned                         mismatch_count = 0;
  int unsigned                         send_idle_pct = 0;
  int unsigned                         recv_stall_pct = 0;
  logic [thrd_pkg::COUNT_W-1:0]        due_count;

  // Strict inside test on the exact squared distance.
  function automatic bit inside_zone(logic signed [thrd_pkg::COORD_W-1:0] x,
                                     logic signed [thrd_pkg::COORD_W-1:0] y);
    longint dx, dy, r;
    dx = longint'(x) - longint'(zone_cx);
    dy = longint'(y) - longint'(zone_cy);
    r  = longint'(zone_r);
    return (dx * dx + dy * dy) < (r * r);
  endfunction

  // Disarm; a hold that was reported ends with a final count of zero.
  function automatic bit end_hold(output logic [thrd_pkg::COUNT_W-1:0] count);
    zone_armed = 1'b0;
    tick_count = '0;
    count      = '0;
    if (hold_seen) begin
      hold_seen  = 1'b0;
      repeat_num = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the predicted state by one request; returns 1 when a count is due.
  function automatic bit predict_hold(thrd_pkg::thrd_cmd_t cmd,
                                      logic signed [thrd_pkg::COORD_W-1:0] x,
                                      logic signed [thrd_pkg::COORD_W-1:0] y,
                                      output logic [thrd_pkg::COUNT_W-1:0] count);
    count = '0;
    case (cmd)
      thrd_pkg::CMD_TICK: begin
        if (!zone_armed) return 1'b0;
        if (tick_count != thrd_pkg::TICK_MAX) tick_count++;
        if (repeat_num == '0) begin
          if (tick_count >= delay_len) begin
            hold_seen  = 1'b1;
            repeat_num = COUNT_ONE;
            tick_count = '0;
            count      = COUNT_ONE;
            return 1'b1;
          end
        end else if (repeat_len != thrd_pkg::INFINITE && tick_count >= repeat_len) begin
          if (repeat_num != thrd_pkg::COUNT_MAX) repeat_num++;
          tick_count = '0;
          count      = repeat_num;
          return 1'b1;
        end
        return 1'b0;
      end
      thrd_pkg::CMD_PRESS: begin
        if (inside_zone(x, y)) begin
          zone_armed = 1'b1;
          tick_count = '0;
          repeat_num = '0;
        end
        return 1'b0;
      end
      thrd_pkg::CMD_MOVE: begin
        if (inside_zone(x, y)) return 1'b0;
        return end_hold(count);
      end
      default: return end_hold(count);
    endcase
  endfunction

  // Receiver side: random stall according to the current idling phase.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted result with the oldest predicted count.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (hold_counts_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: expected none, got hold_count %0d", out_hold_count);
      end else begin
        due_count = hold_counts_due.pop_front();
        if (out_hold_count !== due_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("hold_count mismatch: expected %0d, got %0d", due_count,
                     out_hold_count);
        end
      end
    end
  end

  // Send one request, with a random idle gap first, and predict its result.
  task automatic send_request(thrd_pkg::thrd_cmd_t cmd,
                              logic signed [thrd_pkg::COORD_W-1:0] x,
                              logic signed [thrd_pkg::COORD_W-1:0] y);
    logic [thrd_pkg::COUNT_W-1:0] count;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_pos_x   <= x;
    in_pos_y   <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_hold(cmd, x, y, count)) hold_counts_due.push_back(count);
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_request(thrd_pkg::CMD_TICK, '0, '0);
  endtask

  // Stop sending, wait for every predicted count, then let the pipeline empty.
  task automatic drain;
    in_valid <= 1'b0;
    while (hold_counts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Setup and access cycle on the register port; mirror the value locally.
  task automatic write_register(thrd_pkg::thrd_reg_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      thrd_pkg::REG_CENTRE_X:     zone_cx    = value[thrd_pkg::COORD_W-1:0];
      thrd_pkg::REG_CENTRE_Y:     zone_cy    = value[thrd_pkg::COORD_W-1:0];
      thrd_pkg::REG_ZONE_RADIUS:  zone_r     = value[thrd_pkg::RAD_W-1:0];
      thrd_pkg::REG_DELAY_TICKS:  delay_len  = value[thrd_pkg::TICK_W-1:0];
      thrd_pkg::REG_REPEAT_TICKS: repeat_len = value[thrd_pkg::TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] cx, logic [15:0] cy, logic [14:0] radius,
                           logic [15:0] delay, logic [15:0] rep);
    drain();
    write_register(thrd_pkg::REG_CENTRE_X, {16'h0, cx});
    write_register(thrd_pkg::REG_CENTRE_Y, {16'h0, cy});
    write_register(thrd_pkg::REG_ZONE_RADIUS, {17'h0, radius});
    write_register(thrd_pkg::REG_DELAY_TICKS, {16'h0, delay});
    write_register(thrd_pkg::REG_REPEAT_TICKS, {16'h0, rep});
  endtask

  task automatic set_idling(int unsigned sender, int unsigned receiver);
    send_idle_pct  = sender;
    recv_stall_pct = receiver;
  endtask

  // A coordinate within one radius of a centre coordinate, wrapping at the edges.
  function automatic logic signed [thrd_pkg::COORD_W-1:0] near_coord(
      logic signed [thrd_pkg::COORD_W-1:0] c);
    int span;
    span = int'(zone_r);
    return 16'(int'(c) + int'($urandom_range(2 * span)) - span);
  endfunction

  // Press, hold, repeat, then move outside or release; plus a repeat interval.
  task automatic test_hold_and_repeat;
    configure(16'd100, -16'sd50, 15'd1000, 16'd2, 16'd3);
    send_request(thrd_pkg::CMD_PRESS, 16'sd5000, 16'sd5000);
    send_request(thrd_pkg::CMD_TICK, '0, '0);
    send_request(thrd_pkg::CMD_PRESS, 16'sd100, -16'sd50);
    send_ticks(5);
    send_request(thrd_pkg::CMD_MOVE, 16'sd500, 16'sd300);
    send_request(thrd_pkg::CMD_MOVE, 16'sd2000, 16'sd0);
    // Cancel before any detection gives no result.
    send_request(thrd_pkg::CMD_PRESS, 16'sd0, 16'sd0);
    send_request(thrd_pkg::CMD_RELEASE, 16'sd0, 16'sd0);
    // A second press restarts the delay but still owes the final zero.
    send_request(thrd_pkg::CMD_PRESS, 16'sd0, 16'sd0);
    send_ticks(2);
    send_request(thrd_pkg::CMD_PRESS, 16'sd0, 16'sd0);
    send_request(thrd_pkg::CMD_RELEASE, 16'sd0, 16'sd0);
  endtask

  // Strict boundary, zero delay, no repeat, extreme coordinates, zero radius.
  task automatic test_zone_edges;
    configure(16'd0, 16'd0, 15'd5, 16'd0, thrd_pkg::INFINITE);
    send_request(thrd_pkg::CMD_PRESS, 16'sd3, 16'sd4);
    send_request(thrd_pkg::CMD_TICK, '0, '0);
    send_request(thrd_pkg::CMD_PRESS, 16'sd3, 16'sd3);
    send_ticks(2);
    send_request(thrd_pkg::CMD_RELEASE, -16'sd1, -16'sd1);
    configure(16'h8000, 16'h8000, 15'h7FFF, 16'd0, 16'd1);
    send_request(thrd_pkg::CMD_PRESS, 16'sh7FFF, 16'sh7FFF);
    send_request(thrd_pkg::CMD_PRESS, 16'sh8000, 16'sh8000);
    send_ticks(2);
    send_request(thrd_pkg::CMD_MOVE, 16'sh7FFF, 16'sh8000);
    configure(16'h7FFF, 16'h7FFF, 15'd0, 16'd0, 16'd1);
    send_request(thrd_pkg::CMD_PRESS, 16'sh7FFF, 16'sh7FFF);
    send_request(thrd_pkg::CMD_TICK, '0, '0);
  endtask

  // Mostly press and hold sequences with random content, some random noise.
  task automatic run_random_requests(int unsigned total);
    int unsigned sent;
    int unsigned ticks;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(99) < 75) begin
        send_request(thrd_pkg::CMD_PRESS, near_coord(zone_cx), near_coord(zone_cy));
        ticks = $urandom_range(12);
        repeat (ticks) begin
          if ($urandom_range(99) < 15)
            send_request(thrd_pkg::CMD_MOVE, near_coord(zone_cx), near_coord(zone_cy));
          else
            send_request(thrd_pkg::CMD_TICK, 16'($urandom), 16'($urandom));
        end
        case ($urandom_range(2))
          0: send_request(thrd_pkg::CMD_RELEASE, 16'($urandom), 16'($urandom));
          1: send_request(thrd_pkg::CMD_MOVE, 16'($urandom), 16'($urandom));
          default: ;
        endcase
        sent += 2 + ticks;
      end else begin
        send_request(thrd_pkg::thrd_cmd_t'($urandom_range(3)), 16'($urandom),
                     16'($urandom));
        sent++;
      end
    end
  endtask

  // Random traffic under each idling phase with a different zone each time.
  task automatic test_random_traffic;
    configure(16'd0, 16'd0, 15'h7FFF, 16'd0, 16'd1);
    set_idling(0, 0);
    run_random_requests(125);
    configure(16'h8000, 16'h7FFF, 15'($urandom_range(1, 200)), 16'($urandom_range(5)),
              thrd_pkg::INFINITE);
    set_idling(52, 0);
    run_random_requests(125);
    configure(16'($urandom), 16'($urandom), 15'($urandom_range(50, 5000)),
              16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)));
    set_idling(0, 52);
    run_random_requests(125);
    configure(16'h7FFF, 16'h8000, 15'h7FFF, 16'd3, 16'd2);
    set_idling(38, 38);
    run_random_requests(125);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hold_and_repeat();
    test_zone_edges();
    test_random_traffic();
    drain();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard limit in case the block stops answering.
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> touch_hold_repeat_detector.f
hdl/thrd_pkg.sv
hdl/touch_hold_repeat_detector.sv
tb/tb.sv
